// ----- rtl/mdn_pkg.sv -----
package mdn_pkg;

    localparam int AMP_W   = 24;
    localparam int SEED_W  = 16;
    localparam int DECAY_W = 16;
    localparam int SIZE_W  = 4;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd3;

    localparam logic REQ_GEN  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [23:0] HASH_K1 = 24'd1729731;
    localparam logic [29:0] HASH_K2 = 30'd559184609;

    localparam logic signed [AMP_W-1:0] SAT_MAX = 24'sh7FFFFF;
    localparam logic signed [AMP_W-1:0] SAT_MIN = -24'sh800000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_H0,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_WR,
        ST_DECAY,
        ST_READ,
        ST_READ2,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic accept;
        logic init;
        logic rd_lo;
        logic rd_hi;
        logic hash0;
        logic hash1;
        logic hash2;
        logic hash3;
        logic write;
        logic decay;
        logic rd_user;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic level_done;
        logic all_done;
    } stat_t;

    function automatic logic signed [AMP_W-1:0] sat24(input logic signed [49:0] x);
        if (x > 50'sd8388607) return SAT_MAX;
        if (x < -50'sd8388608) return SAT_MIN;
        return x[AMP_W-1:0];
    endfunction

endpackage

// ----- rtl/mdn_ctrl.sv -----
module mdn_ctrl
    import mdn_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  logic  req_read,
    input  logic  out_free,
    input  stat_t stat,
    output logic  busy,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd.accept = 1'b1;
                    if (req_read == REQ_READ) begin
                        state_next = ST_READ;
                    end else begin
                        cmd.init = 1'b1;
                        state_next = ST_RD_LO;
                    end
                end
            end
            ST_RD_LO: begin cmd.rd_lo = 1'b1; state_next = ST_RD_HI; end
            ST_RD_HI: begin cmd.rd_hi = 1'b1; state_next = ST_H0; end
            ST_H0:    begin cmd.hash0 = 1'b1; state_next = ST_H1; end
            ST_H1:    begin cmd.hash1 = 1'b1; state_next = ST_H2; end
            ST_H2:    begin cmd.hash2 = 1'b1; state_next = ST_H3; end
            ST_H3:    begin cmd.hash3 = 1'b1; state_next = ST_WR; end
            ST_WR: begin
                cmd.write = 1'b1;
                state_next = stat.level_done ? ST_DECAY : ST_RD_LO;
            end
            ST_DECAY: begin
                cmd.decay = 1'b1;
                state_next = stat.all_done ? ST_REPLY : ST_RD_LO;
            end
            ST_READ:  begin cmd.rd_user = 1'b1; state_next = ST_READ2; end
            ST_READ2: begin state_next = ST_REPLY; end
            ST_REPLY: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/mdn_datapath.sv -----
module mdn_datapath
    import mdn_pkg::*;
#(
    parameter int SAMPLE_COUNT = 256,
    parameter int IDX_W = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmd_t                      cmd,
    input  logic [SEED_W-1:0]         noise_seed,
    input  logic signed [AMP_W-1:0]   start_amplitude,
    input  logic [DECAY_W-1:0]        level_decay,
    input  logic [SIZE_W-1:0]         size_log2,
    input  logic                      req_type,
    input  logic [7:0]                sample_index,
    output stat_t                     stat,
    output logic                      reply_kind,
    output logic signed [AMP_W-1:0]   sample_value
);

    localparam int PW = IDX_W + 1;

    logic signed [AMP_W-1:0] mem [SAMPLE_COUNT];
    logic signed [AMP_W-1:0] rdata_reg;
    logic [PW-1:0] n_reg, half_reg, cur_reg;
    logic signed [AMP_W-1:0] amp_reg;
    logic signed [AMP_W-1:0] lo_reg;
    logic lo_zero_reg, hi_zero_reg, rd_oor_reg, kind_reg;
    logic [7:0] idx_reg;
    logic [23:0] f0_reg;
    logic [29:0] f1_reg;
    logic [23:0] h_reg;
    logic signed [49:0] disp_reg;
    logic signed [AMP_W-1:0] out_reg;

    logic [PW-1:0] n_calc;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] hi_idx;
    logic [31:0] hash_arg;
    logic [31:0] k1_prod;
    logic [54:0] f1_prod;
    logic [59:0] f2_prod;
    logic signed [AMP_W:0] mean_sum;
    logic signed [AMP_W-1:0] lo_val, hi_val;
    logic signed [49:0] disp_full;
    logic signed [49:0] next_sample;
    logic signed [41:0] decay_prod;
    logic [PW-1:0] step2;

    always_comb begin
        n_calc = '0;
        for (int k = 1; k <= 12; k++) begin
            if ((k == 1 || size_log2 >= SIZE_W'(k)) && (1 << k) <= SAMPLE_COUNT) begin
                n_calc = PW'(1 << k);
            end
        end
    end

    assign hi_idx = cur_reg + half_reg;
    assign step2 = half_reg << 1;
    assign rd_addr = cmd.rd_lo ? (cur_reg - half_reg) : hi_idx;
    assign hash_arg = 32'(noise_seed) + 32'(cur_reg) + 32'(half_reg);
    assign k1_prod = hash_arg * 32'(HASH_K1);
    assign f1_prod = 55'(f0_reg) * (55'(f0_reg) + 55'(HASH_K2));
    assign f2_prod = 60'(f1_reg) * 60'(f1_reg);
    assign lo_val = lo_zero_reg ? '0 : lo_reg;
    assign hi_val = hi_zero_reg ? '0 : rdata_reg;
    assign mean_sum = (AMP_W+1)'(lo_val) + (AMP_W+1)'(hi_val);
    assign disp_full = $signed({1'b0, h_reg}) * 50'(amp_reg);
    assign next_sample = 50'(mean_sum >>> 1) + (disp_reg >>> 24);
    assign decay_prod = 42'(amp_reg) * $signed({1'b0, level_decay});

    assign stat.level_done = (cur_reg + step2) >= n_reg;
    assign stat.all_done = (half_reg == PW'(1));

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            mem[0] <= '0;
        end else if (cmd.write) begin
            mem[cur_reg[IDX_W-1:0]] <= sat24(next_sample);
        end
        if (cmd.rd_user) begin
            rdata_reg <= mem[IDX_W'(idx_reg)];
        end else if (cmd.rd_lo || cmd.rd_hi) begin
            rdata_reg <= mem[rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            idx_reg <= sample_index;
            kind_reg <= req_type;
            rd_oor_reg <= (32'(sample_index) >= 32'(SAMPLE_COUNT));
        end
        if (cmd.init) begin
            n_reg <= n_calc;
            half_reg <= n_calc >> 1;
            cur_reg <= n_calc >> 1;
            amp_reg <= start_amplitude;
        end
        if (cmd.rd_lo) begin
            lo_zero_reg <= 1'b0;
            hi_zero_reg <= (hi_idx >= n_reg);
        end
        if (cmd.rd_hi) lo_reg <= rdata_reg;
        if (cmd.hash0) f0_reg <= k1_prod[23:0];
        if (cmd.hash1) f1_reg <= f1_prod[53:24];
        if (cmd.hash2) h_reg <= f2_prod[46:23];
        if (cmd.hash3) disp_reg <= disp_full;
        if (cmd.write) cur_reg <= cur_reg + step2;
        if (cmd.decay) begin
            amp_reg <= sat24(50'(decay_prod >>> 14));
            half_reg <= half_reg >> 1;
            cur_reg <= half_reg >> 1;
        end
        if (cmd.load_out) out_reg <= (kind_reg == REQ_READ && !rd_oor_reg) ? rdata_reg : '0;
    end

    logic kind_out_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_out_reg <= 1'b0;
        end else if (cmd.load_out) begin
            kind_out_reg <= kind_reg;
        end
    end

    assign reply_kind = kind_out_reg;
    assign sample_value = out_reg;

endmodule

// ----- rtl/midpoint_displacement_noise.sv -----
// Midpoint displacement noise: a generate beat fills the internal sample store with
// 2^size_log2 points of 1-D noise, clamped to 2..SAMPLE_COUNT, and returns one
// completion beat; a read beat returns one stored sample. Per point a generate does two
// store reads on the single memory port, a four-step hash and scale and one write;
// each level ends with a decay step. A read is an accept, a store read and a reply.
// Reads return meaningful data only after a generate.
module midpoint_displacement_noise
    import mdn_pkg::*;
#(
    parameter int SAMPLE_COUNT = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // sample_index
    input  logic               s_tuser,   // req_type
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // sample_value
    output logic               m_tuser,   // reply_kind
    input  logic               cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int IDX_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;

    logic [SEED_W-1:0]       seed_reg;
    logic signed [AMP_W-1:0] amp_reg;
    logic [DECAY_W-1:0]      decay_reg;
    logic [SIZE_W-1:0]       size_reg;
    logic                    m_valid_reg;
    logic                    busy;
    logic                    start;
    cmd_t                    cmd;
    stat_t                   stat;
    logic signed [AMP_W-1:0] value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg  <= SEED_W'(1234);
            amp_reg   <= '0;
            decay_reg <= DECAY_W'(16384);
            size_reg  <= SIZE_W'(8);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SEED:  seed_reg  <= cfg_data[SEED_W-1:0];
                REG_AMP:   amp_reg   <= cfg_data[AMP_W-1:0];
                REG_DECAY: decay_reg <= cfg_data[DECAY_W-1:0];
                REG_SIZE:  size_reg  <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = aresetn && !busy;
    assign start = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    mdn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .req_read (s_tuser),
        .out_free (!m_valid_reg || m_tready),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    mdn_datapath #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .IDX_W        (IDX_W)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .noise_seed      (seed_reg),
        .start_amplitude (amp_reg),
        .level_decay     (decay_reg),
        .size_log2       (size_reg),
        .req_type        (s_tuser),
        .sample_index    (s_tdata),
        .stat            (stat),
        .reply_kind      (m_tuser),
        .sample_value    (value)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata = value;

endmodule

// ----- rtl/mdn_checker.sv -----
module mdn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    a_gen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 24'd0))
        else $error("generate reply carries data");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a second request while busy");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind midpoint_displacement_noise mdn_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- bench/tb_midpoint_displacement_noise.sv -----
module tb_midpoint_displacement_noise
    import mdn_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = 256;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic        kind;
        logic [23:0] value;
    } reply_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    midpoint_displacement_noise #(.SAMPLE_COUNT(NPTS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow configuration and noise state
    logic [15:0]        seed_q;
    logic signed [23:0] amp_start_q;
    logic [15:0]        decay_q;
    logic [3:0]         size_q;
    logic signed [23:0] samples [NPTS];
    logic               written [NPTS];

    reply_t replies_pending [$];
    int     mismatches;
    int     idle_cycles;
    bit     quiet_sender;
    int     stall_left;

    initial begin
        aclk = 1'b0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clamp_q15_8(input longint x);
        if (x > 64'sd8388607) return 64'sd8388607;
        if (x < -64'sd8388608) return -64'sd8388608;
        return x;
    endfunction

    function automatic longint noise_hash(input int unsigned n);
        logic [63:0] f0;
        logic [63:0] f1;
        logic [63:0] f2;
        f0 = (64'(n) * 64'(HASH_K1)) & 64'hFFFFFF;
        f1 = (f0 * (f0 + 64'(HASH_K2))) >> 24;
        f2 = ((64'd2 * f1 * f1) >> 24) & 64'hFFFFFF;
        return longint'(f2);
    endfunction

    task automatic fill_noise();
        int     lg;
        int     n;
        int     hs;
        int     i;
        longint amp;
        longint disp;
        longint lo;
        longint hi;
        lg = size_q;
        if (lg == 0) lg = 1;
        while (lg > 1 && (1 << lg) > NPTS) lg--;
        n = 1 << lg;
        samples[0] = '0;
        written[0] = 1'b1;
        amp = longint'(amp_start_q);
        for (hs = n / 2; hs > 0; hs = hs / 2) begin
            for (i = hs; i < n; i += 2 * hs) begin
                disp = (noise_hash(int'(seed_q) + i + hs) * amp) >>> 24;
                lo = longint'(samples[i - hs]);
                hi = (i + hs >= n) ? 0 : longint'(samples[i + hs]);
                samples[i] = 24'(clamp_q15_8(((lo + hi) >>> 1) + disp));
                written[i] = 1'b1;
            end
            amp = clamp_q15_8((amp * longint'(decay_q)) >>> 14);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet_sender) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(input logic kind, input logic [7:0] idx);
        int     gap;
        reply_t exp_r;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= idx;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == REQ_GEN) begin
            fill_noise();
            exp_r.kind  = REQ_GEN;
            exp_r.value = '0;
        end else begin
            exp_r.kind  = REQ_READ;
            exp_r.value = samples[idx];
        end
        replies_pending.insert(replies_pending.size(), exp_r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            REG_SEED:  seed_q      = val[15:0];
            REG_AMP:   amp_start_q = val[23:0];
            REG_DECAY: decay_q     = val[15:0];
            REG_SIZE:  size_q      = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [15:0] sd, input logic [23:0] amp,
                           input logic [15:0] dc, input logic [3:0] sz);
        wait_drained();
        write_reg(REG_SEED, CFG_W'(sd));
        write_reg(REG_AMP, amp);
        write_reg(REG_DECAY, CFG_W'(dc));
        write_reg(REG_SIZE, CFG_W'(sz));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] written_index();
        logic [7:0] k;
        k = 8'($urandom);
        while (!written[k]) k = 8'($urandom);
        return k;
    endfunction

    task automatic test_reset_defaults();
        send_beat(REQ_GEN, 8'h00);
        send_beat(REQ_READ, 8'h00);
        send_beat(REQ_READ, 8'hFF);
        send_beat(REQ_READ, 8'h80);
    endtask

    task automatic test_extremes();
        set_all(16'h0000, 24'h7FFFFF, 16'hFFFF, 4'd8);
        send_beat(REQ_GEN, 8'hFF);
        send_beat(REQ_READ, 8'h80);
        send_beat(REQ_READ, 8'h7F);
        send_beat(REQ_READ, 8'h01);
        set_all(16'hFFFF, 24'h800000, 16'hFFFF, 4'd15);
        send_beat(REQ_GEN, 8'h55);
        send_beat(REQ_READ, 8'hC0);
        send_beat(REQ_READ, 8'hAA);
        set_all(16'h1234, 24'h012345, 16'h0000, 4'd0);
        send_beat(REQ_GEN, 8'h00);
        send_beat(REQ_READ, 8'h01);
        send_beat(REQ_READ, 8'h02);
        set_all(16'h00FF, 24'h7FFFFF, 16'h4000, 4'd1);
        send_beat(REQ_GEN, 8'h00);
        send_beat(REQ_READ, 8'h01);
        send_beat(REQ_READ, 8'h00);
    endtask

    task automatic test_held_sender();
        quiet_sender = 1'b1;
        for (int k = 0; k < 30; k++) send_beat(REQ_READ, written_index());
        quiet_sender = 1'b0;
        wait_drained();
        for (int k = 0; k < 10; k++) send_beat(REQ_READ, written_index());
    endtask

    task automatic test_random_phases();
        int          sent;
        int          r;
        logic [23:0] amp;
        logic [15:0] dc;
        logic [3:0]  sz;
        sent = 0;
        while (sent < 500) begin
            r = $urandom_range(0, 9);
            amp = (r == 0) ? 24'h7FFFFF : (r == 1) ? 24'h800000 : 24'($urandom);
            r = $urandom_range(0, 9);
            dc = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0000 : 16'($urandom_range(4096, 24000));
            r = $urandom_range(0, 19);
            sz = (r == 0) ? 4'd8 : (r == 1) ? 4'($urandom_range(9, 15)) :
                 4'($urandom_range(0, 5));
            set_all(16'($urandom), amp, dc, sz);
            quiet_sender = ($urandom_range(0, 3) == 0);
            send_beat(REQ_GEN, 8'($urandom));
            sent++;
            for (int k = $urandom_range(10, 40); k > 0; k--) begin
                if ($urandom_range(0, 29) == 0) send_beat(REQ_GEN, 8'($urandom));
                else send_beat(REQ_READ, written_index());
                sent++;
            end
            quiet_sender = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) < 7) begin
            m_tready <= 1'b1;
        end else begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                      : $urandom_range(0, 2);
        end
    end

    always @(posedge aclk) begin
        reply_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: kind %0b value %h", m_tuser, m_tdata);
            end else begin
                exp_r = replies_pending.pop_front();
                if (m_tuser !== exp_r.kind || m_tdata !== exp_r.value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply mismatch: expected kind %0b value %h, got kind %0b value %h",
                                 exp_r.kind, exp_r.value, m_tuser, m_tdata);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_midpoint_displacement_noise failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        idle_cycles  = 0;
        quiet_sender = 1'b0;
        seed_q       = 16'd1234;
        amp_start_q  = '0;
        decay_q      = 16'd16384;
        size_q       = 4'd8;
        for (int k = 0; k < NPTS; k++) begin
            samples[k] = '0;
            written[k] = 1'b0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_extremes();
        test_held_sender();
        test_random_phases();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && replies_pending.size() == 0) begin
            $display("tb_midpoint_displacement_noise passed");
        end else begin
            $display("tb_midpoint_displacement_noise failed");
        end
        $finish;
    end

endmodule
